/* sv/modbus_rtu_slave_engine_macros.svh */
`ifndef MODBUS_RTU_SLAVE_ENGINE_MACROS_SVH
`define MODBUS_RTU_SLAVE_ENGINE_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define MBRTU_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication.
`define MBRTU_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* sv/mbrtu_pkg.sv */
`default_nettype none

package mbrtu_pkg;

	localparam int unsigned FRAME_MAX         = 257;
	localparam int unsigned FRAME_AW          = 9;
	localparam int unsigned QUEUE_DEPTH       = 4;
	localparam int unsigned REG_COUNT_DEFAULT = 256;

	localparam logic [2:0] OP_BYTE   = 3'd0;
	localparam logic [2:0] OP_FINAL  = 3'd1;
	localparam logic [2:0] OP_RXERR  = 3'd2;
	localparam logic [2:0] OP_LWRITE = 3'd3;
	localparam logic [2:0] OP_LREAD  = 3'd4;

	localparam logic [7:0] FN_READ_HOLD  = 8'h03;
	localparam logic [7:0] FN_READ_INPUT = 8'h04;
	localparam logic [7:0] FN_WRITE_MULT = 8'h10;
	localparam logic [7:0] FN_DIAG       = 8'h08;
	localparam logic [7:0] FN_EXC_FLAG   = 8'h80;

	localparam logic [7:0] EXC_FUNCTION = 8'h01;
	localparam logic [7:0] EXC_ADDRESS  = 8'h02;
	localparam logic [7:0] EXC_VALUE    = 8'h03;

	localparam logic [7:0] READ_MAX  = 8'd125;
	localparam logic [7:0] WRITE_MAX = 8'd123;
	localparam logic [8:0] REPLY_MAX = 9'd254;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [1:0] APB_REG_SLAVE = 2'd0;

	typedef enum logic [2:0] {
		CMD_BYTE,
		CMD_FINAL,
		CMD_LWRITE,
		CMD_LREAD
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic        store;
		logic [8:0]  pos;
		logic [7:0]  data;
		logic [8:0]  length;
		logic        too_long;
		logic [7:0]  idx;
		logic [15:0] value;
	} cmd_t;

	typedef struct packed {
		logic            kind;
		logic [3:0][7:0] bytes;
		logic [2:0]      count;
		logic            last;
		logic [15:0]     value;
	} out_t;

	typedef enum logic [1:0] {
		MODE_READ,
		MODE_WRITE,
		MODE_ECHO,
		MODE_EXC
	} mode_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHK,
		ST_CRC_RD,
		ST_CRC_UPD,
		ST_DEC,
		ST_WR_HI,
		ST_WR_LO,
		ST_WR_ST,
		ST_EM_A,
		ST_EM_B,
		ST_LR_A,
		ST_LR_B
	} state_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* sv/modbus_rtu_slave_engine.sv */
// Modbus RTU slave. Push one word per received byte (final byte flagged), a
// receive error, or a local register read or write; pop replies as words of up
// to four bytes, plus one word per local read. The final byte of a frame starts
// the CRC check, which reads the frame back byte by byte through the one
// frame-store read port; the registers of a write request are written one by
// one, and reply bytes are made one by one (CRC is folded in serially). After
// reset the register store is cleared, during which full stays high.
// Broadcasts are carried out but not answered.
`default_nettype none

`include "modbus_rtu_slave_engine_macros.svh"

module modbus_rtu_slave_engine #(
	parameter int unsigned REG_COUNT = mbrtu_pkg::REG_COUNT_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  op,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [7:0]  reg_index,
	input  wire logic [15:0] reg_value,
	output logic             empty,
	input  wire logic        pop,
	output logic             kind,
	output logic [7:0]       tx_byte0,
	output logic [7:0]       tx_byte1,
	output logic [7:0]       tx_byte2,
	output logic [7:0]       tx_byte3,
	output logic [2:0]       tx_count,
	output logic             tx_last,
	output logic [15:0]      local_value,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [7:0] slave_address_q;
	logic [7:0] last_register_q;

	mbrtu_pkg::cmd_t cmd_in;
	mbrtu_pkg::cmd_t cmd_out;
	logic            cmd_push;
	logic            cmd_full;
	logic            cmd_pop;
	logic            cmd_empty;

	mbrtu_pkg::out_t outq_in;
	mbrtu_pkg::out_t outq_out;
	logic            outq_push;
	logic            outq_full;

	logic clearing;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2:1] == mbrtu_pkg::APB_REG_SLAVE) ?
		{24'h000000, slave_address_q} : {24'h000000, last_register_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= 8'd1;
			last_register_q <= 8'd255;
		end else if (cfg_wr) begin
			if (paddr[2:1] == mbrtu_pkg::APB_REG_SLAVE) begin
				slave_address_q <= pwdata[7:0];
			end else begin
				last_register_q <= pwdata[7:0];
			end
		end
	end

	mbrtu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.op        (op),
		.rx_byte   (rx_byte),
		.reg_index (reg_index),
		.reg_value (reg_value),
		.clearing  (clearing),
		.q_full    (cmd_full),
		.q_push    (cmd_push),
		.q_data    (cmd_in)
	);

	mbrtu_fifo #(
		.WIDTH ($bits(mbrtu_pkg::cmd_t)),
		.DEPTH (mbrtu_pkg::QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	mbrtu_back #(
		.REG_COUNT (REG_COUNT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd_out),
		.cmd_empty     (cmd_empty),
		.cmd_pop       (cmd_pop),
		.slave_address (slave_address_q),
		.last_register (last_register_q),
		.outq_full     (outq_full),
		.outq_push     (outq_push),
		.outq_data     (outq_in),
		.clearing      (clearing)
	);

	mbrtu_fifo #(
		.WIDTH ($bits(mbrtu_pkg::out_t)),
		.DEPTH (mbrtu_pkg::QUEUE_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (outq_push),
		.wdata  (outq_in),
		.full   (outq_full),
		.pop    (pop),
		.rdata  (outq_out),
		.empty  (empty)
	);

	assign kind        = outq_out.kind;
	assign tx_byte0    = outq_out.bytes[0];
	assign tx_byte1    = outq_out.bytes[1];
	assign tx_byte2    = outq_out.bytes[2];
	assign tx_byte3    = outq_out.bytes[3];
	assign tx_count    = outq_out.count;
	assign tx_last     = outq_out.last;
	assign local_value = outq_out.value;

	`MBRTU_ASSERT_IMP(a_no_accept_clearing, clearing, full)
	`MBRTU_ASSERT_IMP(a_outq_push_space, outq_push, !outq_full)
	`MBRTU_ASSERT_IMP(a_cmd_pop_valid, cmd_pop, !cmd_empty)
	`MBRTU_ASSERT_NXT(a_clear_done_idle, $fell(clearing), !clearing)

endmodule

`default_nettype wire

/* sv/mbrtu_fifo.sv */
`default_nettype none

module mbrtu_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = mbrtu_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [AW:0]      cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

/* sv/mbrtu_front.sv */
`default_nettype none

module mbrtu_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              full,
	input  wire logic [2:0]   op,
	input  wire logic [7:0]   rx_byte,
	input  wire logic [7:0]   reg_index,
	input  wire logic [15:0]  reg_value,
	input  wire logic         clearing,
	input  wire logic         q_full,
	output logic              q_push,
	output mbrtu_pkg::cmd_t   q_data
);

	logic [8:0] len_q;
	logic       too_long_q;
	logic       accept;
	logic       store;

	assign full   = q_full || clearing;
	assign accept = push && !full;
	assign store  = (len_q < 9'(mbrtu_pkg::FRAME_MAX));

	always_comb begin
		q_data          = '0;
		q_data.kind     = mbrtu_pkg::CMD_BYTE;
		q_data.store    = store;
		q_data.pos      = len_q;
		q_data.data     = rx_byte;
		q_data.length   = store ? len_q + 9'd1 : len_q;
		q_data.too_long = too_long_q || !store;
		q_data.idx      = reg_index;
		q_data.value    = reg_value;
		q_push          = 1'b0;
		case (op)
			mbrtu_pkg::OP_BYTE: begin
				q_push = accept && store;
			end
			mbrtu_pkg::OP_FINAL: begin
				q_data.kind = mbrtu_pkg::CMD_FINAL;
				q_push      = accept;
			end
			mbrtu_pkg::OP_LWRITE: begin
				q_data.kind = mbrtu_pkg::CMD_LWRITE;
				q_push      = accept;
			end
			mbrtu_pkg::OP_LREAD: begin
				q_data.kind = mbrtu_pkg::CMD_LREAD;
				q_push      = accept;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			too_long_q <= 1'b0;
		end else if (accept) begin
			case (op)
				mbrtu_pkg::OP_BYTE: begin
					if (store) begin
						len_q <= len_q + 9'd1;
					end else begin
						too_long_q <= 1'b1;
					end
				end
				mbrtu_pkg::OP_FINAL, mbrtu_pkg::OP_RXERR: begin
					len_q      <= '0;
					too_long_q <= 1'b0;
				end
				default: begin
					len_q <= len_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/mbrtu_back.sv */
`default_nettype none

module mbrtu_back #(
	parameter int unsigned REG_COUNT = mbrtu_pkg::REG_COUNT_DEFAULT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mbrtu_pkg::cmd_t  cmd,
	input  wire logic             cmd_empty,
	output logic                  cmd_pop,
	input  wire logic [7:0]       slave_address,
	input  wire logic [7:0]       last_register,
	input  wire logic             outq_full,
	output logic                  outq_push,
	output mbrtu_pkg::out_t       outq_data,
	output logic                  clearing
);

	localparam int unsigned RIW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	mbrtu_pkg::state_t state_q, state_d;
	mbrtu_pkg::mode_t  mode_q, dec_mode;

	logic [7:0]  fmem [mbrtu_pkg::FRAME_MAX];
	logic [15:0] rmem [REG_COUNT];
	logic [7:0]  frd_q;
	logic [15:0] rrd_q;

	logic [RIW-1:0] clr_q;
	logic [15:0]    crc_q;
	logic [8:0]     idx_q;
	logic [8:0]     len_q;
	logic           too_long_q;
	logic [7:0]     fb_q [7];
	logic [7:0]     blast_q;
	logic [7:0]     bprev_q;
	logic [7:0]     code_q;
	logic [8:0]     rlen_q;
	logic           drop_q;
	logic [15:0]    ri_q;
	logic [7:0]     rem_q;
	logic [8:0]     pos_q;
	logic [7:0]     hi_q;
	logic [7:0]     bcnt_q;
	logic [7:0]     chunk_q [4];
	logic [1:0]     cslot_q;
	logic           lr_ok_q;

	logic                          fwe;
	logic [mbrtu_pkg::FRAME_AW-1:0] fwaddr;
	logic [mbrtu_pkg::FRAME_AW-1:0] fraddr;
	logic           rwe;
	logic [RIW-1:0] rwaddr;
	logic [15:0]    rwdata;

	// Request decode, valid while in the decode state.
	logic [8:0]  dl;
	logic [7:0]  fbv [7];
	logic [15:0] start;
	logic [7:0]  cnt;
	logic [16:0] last_idx;
	logic        range_bad;
	logic [7:0]  dec_code;
	logic [8:0]  dec_rlen;
	logic        dec_drop;

	// Reply byte generation.
	logic        em_last;
	logic        em_crc;
	logic [7:0]  em_byte;
	logic        em_chunk_done;

	always_comb begin
		dl = len_q - 9'd3;
		for (int i = 0; i < 7; i++) begin
			fbv[i] = (9'(i) <= dl) ? fb_q[i] : 8'h00;
		end
		start     = {fbv[2], fbv[3]};
		cnt       = fbv[5];
		last_idx  = {1'b0, start} + {9'd0, cnt} - 17'd1;
		range_bad = (last_idx > 17'h0FFFF) || (last_idx > {9'd0, last_register}) ||
			(32'(last_idx) >= REG_COUNT);
		dec_mode  = mbrtu_pkg::MODE_EXC;
		dec_code  = mbrtu_pkg::EXC_FUNCTION;
		dec_rlen  = 9'd3;
		case (fbv[1])
			mbrtu_pkg::FN_READ_HOLD, mbrtu_pkg::FN_READ_INPUT: begin
				if (dl != 9'd5 || fbv[4] != 8'h00 || cnt > mbrtu_pkg::READ_MAX ||
					cnt == 8'h00) begin
					dec_code = mbrtu_pkg::EXC_VALUE;
				end else if (range_bad) begin
					dec_code = mbrtu_pkg::EXC_ADDRESS;
				end else begin
					dec_mode = mbrtu_pkg::MODE_READ;
					dec_rlen = 9'd3 + {cnt, 1'b0};
				end
			end
			mbrtu_pkg::FN_WRITE_MULT: begin
				if (fbv[4] != 8'h00 || cnt > mbrtu_pkg::WRITE_MAX || cnt == 8'h00) begin
					dec_code = mbrtu_pkg::EXC_VALUE;
				end else if ({1'b0, fbv[6]} != {cnt, 1'b0} || dl < 9'd6 ||
					(dl - 9'd6) != {1'b0, fbv[6]}) begin
					dec_code = mbrtu_pkg::EXC_VALUE;
				end else if (range_bad) begin
					dec_code = mbrtu_pkg::EXC_ADDRESS;
				end else begin
					dec_mode = mbrtu_pkg::MODE_WRITE;
					dec_rlen = 9'd6;
				end
			end
			mbrtu_pkg::FN_DIAG: begin
				if (fbv[2] == 8'h00 && fbv[3] == 8'h00) begin
					dec_mode = mbrtu_pkg::MODE_ECHO;
					dec_rlen = dl + 9'd1;
				end
			end
			default: begin
				dec_code = mbrtu_pkg::EXC_FUNCTION;
			end
		endcase
		// Broadcasts and oversized answers are carried out but never sent.
		dec_drop = (fbv[0] == 8'h00) || (dec_rlen > mbrtu_pkg::REPLY_MAX);
	end

	always_comb begin
		em_last = (idx_q == rlen_q + 9'd1);
		em_crc  = (idx_q >= rlen_q);
		em_byte = 8'h00;
		if (idx_q == rlen_q) begin
			em_byte = crc_q[7:0];
		end else if (em_last) begin
			em_byte = crc_q[15:8];
		end else begin
			case (mode_q)
				mbrtu_pkg::MODE_EXC: begin
					if (idx_q == 9'd0) begin
						em_byte = fb_q[0];
					end else if (idx_q == 9'd1) begin
						em_byte = fb_q[1] + mbrtu_pkg::FN_EXC_FLAG;
					end else begin
						em_byte = code_q;
					end
				end
				mbrtu_pkg::MODE_WRITE: begin
					em_byte = fb_q[idx_q[2:0]];
				end
				mbrtu_pkg::MODE_ECHO: begin
					em_byte = frd_q;
				end
				mbrtu_pkg::MODE_READ: begin
					if (idx_q == 9'd0) begin
						em_byte = fb_q[0];
					end else if (idx_q == 9'd1) begin
						em_byte = fb_q[1];
					end else if (idx_q == 9'd2) begin
						em_byte = bcnt_q;
					end else if (idx_q[0]) begin
						em_byte = rrd_q[15:8];
					end else begin
						em_byte = rrd_q[7:0];
					end
				end
				default: begin
					em_byte = 8'h00;
				end
			endcase
		end
		em_chunk_done = (cslot_q == 2'd3) || em_last;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mbrtu_pkg::ST_CLEAR: begin
				if (clr_q == RIW'(REG_COUNT - 1)) begin
					state_d = mbrtu_pkg::ST_IDLE;
				end
			end
			mbrtu_pkg::ST_IDLE: begin
				if (!cmd_empty) begin
					case (cmd.kind)
						mbrtu_pkg::CMD_FINAL: state_d = mbrtu_pkg::ST_CHK;
						mbrtu_pkg::CMD_LREAD: state_d = mbrtu_pkg::ST_LR_A;
						default:              state_d = mbrtu_pkg::ST_IDLE;
					endcase
				end
			end
			mbrtu_pkg::ST_CHK: begin
				if (too_long_q || len_q < 9'd4 ||
					(fb_q[0] != slave_address && fb_q[0] != 8'h00)) begin
					state_d = mbrtu_pkg::ST_IDLE;
				end else begin
					state_d = mbrtu_pkg::ST_CRC_RD;
				end
			end
			mbrtu_pkg::ST_CRC_RD: begin
				state_d = mbrtu_pkg::ST_CRC_UPD;
			end
			mbrtu_pkg::ST_CRC_UPD: begin
				if (idx_q + 9'd1 == len_q - 9'd2) begin
					state_d = mbrtu_pkg::ST_DEC;
				end else begin
					state_d = mbrtu_pkg::ST_CRC_RD;
				end
			end
			mbrtu_pkg::ST_DEC: begin
				if (crc_q != {blast_q, bprev_q}) begin
					state_d = mbrtu_pkg::ST_IDLE;
				end else if (dec_mode == mbrtu_pkg::MODE_WRITE) begin
					state_d = mbrtu_pkg::ST_WR_HI;
				end else if (dec_drop) begin
					state_d = mbrtu_pkg::ST_IDLE;
				end else begin
					state_d = mbrtu_pkg::ST_EM_A;
				end
			end
			mbrtu_pkg::ST_WR_HI: begin
				state_d = mbrtu_pkg::ST_WR_LO;
			end
			mbrtu_pkg::ST_WR_LO: begin
				state_d = mbrtu_pkg::ST_WR_ST;
			end
			mbrtu_pkg::ST_WR_ST: begin
				if (rem_q != 8'd1) begin
					state_d = mbrtu_pkg::ST_WR_HI;
				end else if (drop_q) begin
					state_d = mbrtu_pkg::ST_IDLE;
				end else begin
					state_d = mbrtu_pkg::ST_EM_A;
				end
			end
			mbrtu_pkg::ST_EM_A: begin
				if (!outq_full) begin
					state_d = mbrtu_pkg::ST_EM_B;
				end
			end
			mbrtu_pkg::ST_EM_B: begin
				state_d = em_last ? mbrtu_pkg::ST_IDLE : mbrtu_pkg::ST_EM_A;
			end
			mbrtu_pkg::ST_LR_A: begin
				if (!outq_full) begin
					state_d = mbrtu_pkg::ST_LR_B;
				end
			end
			mbrtu_pkg::ST_LR_B: begin
				state_d = mbrtu_pkg::ST_IDLE;
			end
			default: begin
				state_d = mbrtu_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		clearing  = 1'b0;
		fwe       = 1'b0;
		fwaddr    = cmd.pos;
		fraddr    = idx_q;
		rwe       = 1'b0;
		rwaddr    = clr_q;
		rwdata    = 16'h0000;
		outq_push = 1'b0;
		outq_data = '0;
		case (state_q)
			mbrtu_pkg::ST_CLEAR: begin
				clearing = 1'b1;
				rwe      = 1'b1;
			end
			mbrtu_pkg::ST_IDLE: begin
				cmd_pop = !cmd_empty;
				if (!cmd_empty) begin
					case (cmd.kind)
						mbrtu_pkg::CMD_BYTE, mbrtu_pkg::CMD_FINAL: begin
							fwe = cmd.store;
						end
						mbrtu_pkg::CMD_LWRITE: begin
							rwe    = (32'(cmd.idx) < REG_COUNT);
							rwaddr = RIW'(cmd.idx);
							rwdata = cmd.value;
						end
						default: begin
							fwe = 1'b0;
						end
					endcase
				end
			end
			mbrtu_pkg::ST_WR_HI: begin
				fraddr = pos_q;
			end
			mbrtu_pkg::ST_WR_LO: begin
				fraddr = pos_q + 9'd1;
			end
			mbrtu_pkg::ST_WR_ST: begin
				rwe    = 1'b1;
				rwaddr = ri_q[RIW-1:0];
				rwdata = {hi_q, frd_q};
			end
			mbrtu_pkg::ST_EM_B: begin
				outq_push = em_chunk_done;
				outq_data.count = 3'(cslot_q) + 3'd1;
				outq_data.last  = em_last;
				for (int k = 0; k < 4; k++) begin
					if (2'(k) < cslot_q) begin
						outq_data.bytes[k] = chunk_q[k];
					end else if (2'(k) == cslot_q) begin
						outq_data.bytes[k] = em_byte;
					end else begin
						outq_data.bytes[k] = 8'h00;
					end
				end
			end
			mbrtu_pkg::ST_LR_B: begin
				outq_push       = 1'b1;
				outq_data.kind  = 1'b1;
				outq_data.value = lr_ok_q ? rrd_q : 16'h0000;
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fwe) begin
			fmem[fwaddr] <= cmd.data;
		end
		frd_q <= fmem[fraddr];
	end

	always_ff @(posedge clk) begin
		if (rwe) begin
			rmem[rwaddr] <= rwdata;
		end
		rrd_q <= rmem[ri_q[RIW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbrtu_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == mbrtu_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mbrtu_pkg::ST_IDLE: begin
				if (!cmd_empty) begin
					if ((cmd.kind == mbrtu_pkg::CMD_BYTE || cmd.kind == mbrtu_pkg::CMD_FINAL) &&
						cmd.store) begin
						if (cmd.pos < 9'd7) begin
							fb_q[cmd.pos[2:0]] <= cmd.data;
						end
						bprev_q <= blast_q;
						blast_q <= cmd.data;
					end
					len_q      <= cmd.length;
					too_long_q <= cmd.too_long;
					crc_q      <= mbrtu_pkg::CRC_INIT;
					idx_q      <= '0;
					ri_q       <= {8'h00, cmd.idx};
					lr_ok_q    <= (32'(cmd.idx) < REG_COUNT);
				end
			end
			mbrtu_pkg::ST_CRC_UPD: begin
				crc_q <= mbrtu_pkg::crc_byte(crc_q, frd_q);
				idx_q <= idx_q + 9'd1;
			end
			mbrtu_pkg::ST_DEC: begin
				mode_q  <= dec_mode;
				code_q  <= dec_code;
				rlen_q  <= dec_rlen;
				drop_q  <= dec_drop;
				ri_q    <= start;
				rem_q   <= cnt;
				bcnt_q  <= {cnt[6:0], 1'b0};
				pos_q   <= 9'd7;
				crc_q   <= mbrtu_pkg::CRC_INIT;
				idx_q   <= '0;
				cslot_q <= '0;
			end
			mbrtu_pkg::ST_WR_LO: begin
				hi_q <= frd_q;
			end
			mbrtu_pkg::ST_WR_ST: begin
				ri_q  <= ri_q + 16'd1;
				pos_q <= pos_q + 9'd2;
				rem_q <= rem_q - 8'd1;
				if (rem_q == 8'd1) begin
					// After the last write the register index goes back to the start address.
					ri_q <= start;
				end
			end
			mbrtu_pkg::ST_EM_B: begin
				if (!em_crc) begin
					crc_q <= mbrtu_pkg::crc_byte(crc_q, em_byte);
				end
				if (mode_q == mbrtu_pkg::MODE_READ && idx_q >= 9'd3 && !idx_q[0] && !em_crc) begin
					ri_q <= ri_q + 16'd1;
				end
				chunk_q[cslot_q] <= em_byte;
				cslot_q <= cslot_q + 2'd1;
				idx_q   <= idx_q + 9'd1;
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

endmodule

`default_nettype wire

/* dv/modbus_rtu_slave_engine_tb.sv */
`default_nettype none

module modbus_rtu_slave_engine_tb;

	localparam int unsigned REGS        = 256;
	localparam int unsigned QUIET_WAIT  = 1500;
	localparam int unsigned STALL_LIMIT = 10000;

	localparam logic [2:0] ADDR_SLAVE    = 3'd0;
	localparam logic [2:0] ADDR_LAST_REG = 3'd4;
	localparam logic [2:0] OP_SPARE_LO   = 3'd5;
	localparam logic [2:0] OP_SPARE_HI   = 3'd7;
	localparam logic [7:0] FN_CUSTOM_A   = 8'h64;
	localparam logic [7:0] FN_CUSTOM_B   = 8'h65;
	localparam logic [7:0] BROADCAST     = 8'h00;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		logic        kind;
		logic [7:0]  tx_b[4];
		logic [2:0]  cnt;
		logic        last;
		logic [15:0] value;
	} reply_word_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [2:0]  op;
	logic [7:0]  rx_byte;
	logic [7:0]  reg_index;
	logic [15:0] reg_value;
	logic        empty;
	logic        pop;
	logic        kind;
	logic [7:0]  tx_byte0, tx_byte1, tx_byte2, tx_byte3;
	logic [2:0]  tx_count;
	logic        tx_last;
	logic [15:0] local_value;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	modbus_rtu_slave_engine u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .op(op),
		.rx_byte(rx_byte), .reg_index(reg_index), .reg_value(reg_value),
		.empty(empty), .pop(pop), .kind(kind), .tx_byte0(tx_byte0),
		.tx_byte1(tx_byte1), .tx_byte2(tx_byte2), .tx_byte3(tx_byte3),
		.tx_count(tx_count), .tx_last(tx_last), .local_value(local_value),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Slave state as the engine should hold it.
	logic [7:0]  own_address;
	logic [7:0]  top_register;
	logic [7:0]  rx_frame[mbrtu_pkg::FRAME_MAX];
	int          rx_len;
	logic        rx_overflow;
	logic [15:0] holding_regs[REGS];
	reply_word_t pending_replies[$];

	int err_count;
	int words_checked;
	int items_sent;
	int frames_sent;
	int idle_pct;
	int stall_pct;
	int quiet_cycles;

	function automatic logic [15:0] crc_of(byte_q_t d);
		logic [15:0] c;
		c = 16'hFFFF;
		foreach (d[i]) begin
			c ^= {8'h00, d[i]};
			for (int b = 0; b < 8; b++) begin
				c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
			end
		end
		return c;
	endfunction

	function automatic byte_q_t with_crc(byte_q_t f);
		logic [15:0] c;
		c = crc_of(f);
		f.push_back(c[7:0]);
		f.push_back(c[15:8]);
		return f;
	endfunction

	function automatic void queue_reply(byte_q_t r);
		reply_word_t w;
		int pos;
		pos = 0;
		while (pos < r.size()) begin
			w.kind = 1'b0;
			w.value = '0;
			w.cnt = '0;
			for (int c = 0; c < 4; c++) begin
				w.tx_b[c] = '0;
			end
			while (w.cnt < 4 && pos < r.size()) begin
				w.tx_b[w.cnt] = r[pos];
				w.cnt++;
				pos++;
			end
			w.last = (pos >= r.size());
			pending_replies.push_back(w);
		end
	endfunction

	function automatic void execute_frame();
		byte_q_t body;
		byte_q_t rep;
		logic [7:0] fb[7];
		int data_last;
		int start, cnt, stop, pos;
		logic fail;
		logic [7:0] code;
		logic [15:0] c;
		fail = 1'b0;
		code = '0;
		if (rx_overflow || rx_len < 4) begin
			return;
		end
		if (rx_frame[0] != own_address && rx_frame[0] != BROADCAST) begin
			return;
		end
		for (int i = 0; i < rx_len - 2; i++) begin
			body.push_back(rx_frame[i]);
		end
		c = crc_of(body);
		if (rx_frame[rx_len-1] != c[15:8] || rx_frame[rx_len-2] != c[7:0]) begin
			return;
		end
		data_last = rx_len - 3;
		for (int i = 0; i < 7; i++) begin
			fb[i] = (i <= data_last) ? rx_frame[i] : 8'h00;
		end
		start = {fb[2], fb[3]};
		cnt = fb[5];
		stop = start + cnt - 1;
		case (fb[1])
			mbrtu_pkg::FN_READ_HOLD, mbrtu_pkg::FN_READ_INPUT: begin
				if (data_last != 5 || fb[4] != 0 || cnt > mbrtu_pkg::READ_MAX ||
						cnt < 1) begin
					fail = 1'b1;
					code = mbrtu_pkg::EXC_VALUE;
				end else if (stop > top_register || stop >= REGS) begin
					fail = 1'b1;
					code = mbrtu_pkg::EXC_ADDRESS;
				end else begin
					rep = {fb[0], fb[1], 8'(2 * cnt)};
					for (int i = start; i <= stop; i++) begin
						rep.push_back(holding_regs[i][15:8]);
						rep.push_back(holding_regs[i][7:0]);
					end
				end
			end
			mbrtu_pkg::FN_WRITE_MULT: begin
				if (fb[4] != 0 || cnt > mbrtu_pkg::WRITE_MAX || cnt < 1 || fb[6] != 2 * cnt
						|| fb[6] != data_last - 6) begin
					fail = 1'b1;
					code = mbrtu_pkg::EXC_VALUE;
				end else if (stop > top_register || stop >= REGS) begin
					fail = 1'b1;
					code = mbrtu_pkg::EXC_ADDRESS;
				end else begin
					pos = 7;
					for (int i = start; i <= stop; i++) begin
						holding_regs[i] = {rx_frame[pos], rx_frame[pos+1]};
						pos += 2;
					end
					rep = {fb[0], fb[1], fb[2], fb[3], fb[4], fb[5]};
				end
			end
			mbrtu_pkg::FN_DIAG: begin
				if (fb[2] == 0 && fb[3] == 0) begin
					for (int i = 0; i <= data_last; i++) begin
						rep.push_back(rx_frame[i]);
					end
				end else begin
					fail = 1'b1;
					code = mbrtu_pkg::EXC_FUNCTION;
				end
			end
			default: begin
				fail = 1'b1;
				code = mbrtu_pkg::EXC_FUNCTION;
			end
		endcase
		if (fail) begin
			rep = {fb[0], 8'(fb[1] + mbrtu_pkg::FN_EXC_FLAG), code};
		end
		// Broadcasts and oversized answers leave nothing on the line.
		if (fb[0] == BROADCAST || rep.size() > mbrtu_pkg::REPLY_MAX) begin
			return;
		end
		queue_reply(with_crc(rep));
	endfunction

	function automatic void predict_item(logic [2:0] o, logic [7:0] b, logic [7:0] idx,
			logic [15:0] val);
		reply_word_t w;
		case (o)
			mbrtu_pkg::OP_BYTE, mbrtu_pkg::OP_FINAL: begin
				if (rx_len < mbrtu_pkg::FRAME_MAX) begin
					rx_frame[rx_len] = b;
					rx_len++;
				end else begin
					rx_overflow = 1'b1;
				end
				if (o == mbrtu_pkg::OP_FINAL) begin
					execute_frame();
					rx_len = 0;
					rx_overflow = 1'b0;
				end
			end
			mbrtu_pkg::OP_RXERR: begin
				rx_len = 0;
				rx_overflow = 1'b0;
			end
			mbrtu_pkg::OP_LWRITE: holding_regs[idx] = val;
			mbrtu_pkg::OP_LREAD: begin
				w.kind = 1'b1;
				for (int c = 0; c < 4; c++) begin
					w.tx_b[c] = '0;
				end
				w.cnt = '0;
				w.last = 1'b0;
				w.value = holding_regs[idx];
				pending_replies.push_back(w);
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(logic [2:0] o, logic [7:0] b, logic [7:0] idx, logic [15:0] val);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		op <= o;
		rx_byte <= b;
		reg_index <= idx;
		reg_value <= val;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		predict_item(o, b, idx, val);
		if (o <= mbrtu_pkg::OP_LREAD) begin
			items_sent++;
		end
	endtask

	task automatic send_frame(byte_q_t f);
		for (int i = 0; i < f.size(); i++) begin
			send_item((i == f.size() - 1) ? mbrtu_pkg::OP_FINAL : mbrtu_pkg::OP_BYTE, f[i],
				8'($urandom), 16'($urandom));
		end
		frames_sent++;
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0) begin
			@(posedge clk);
		end
		repeat (QUIET_WAIT) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_SLAVE) begin
			own_address = data[7:0];
		end else begin
			top_register = data[7:0];
		end
	endtask

	task automatic configure(logic [7:0] addr_value, logic [7:0] top_value);
		drain();
		apb_write(ADDR_SLAVE, {24'h0, addr_value});
		apb_write(ADDR_LAST_REG, {24'h0, top_value});
	endtask

	function automatic byte_q_t read_req(logic [7:0] a, logic [7:0] fn, logic [15:0] start,
			logic [7:0] cnt);
		return with_crc({a, fn, start[15:8], start[7:0], 8'h00, cnt});
	endfunction

	function automatic byte_q_t write_req(logic [7:0] a, logic [15:0] start, logic [7:0] cnt,
			logic [7:0] byte_cnt);
		byte_q_t f;
		f = {a, mbrtu_pkg::FN_WRITE_MULT, start[15:8], start[7:0], 8'h00, cnt, byte_cnt};
		for (int i = 0; i < 2 * cnt; i++) begin
			f.push_back(8'($urandom));
		end
		return with_crc(f);
	endfunction

	function automatic byte_q_t diag_req(logic [7:0] a, logic [15:0] sub, int n);
		byte_q_t f;
		f = {a, mbrtu_pkg::FN_DIAG, sub[15:8], sub[7:0]};
		for (int i = 0; i < n; i++) begin
			f.push_back(8'($urandom));
		end
		return with_crc(f);
	endfunction

	task automatic test_basic_functions();
		send_frame(write_req(own_address, 16'd0, 8'd2, 8'd4));
		send_frame(read_req(own_address, mbrtu_pkg::FN_READ_HOLD, 16'd0, 8'd2));
		send_frame(read_req(own_address, mbrtu_pkg::FN_READ_INPUT, 16'd1, 8'd1));
		send_frame(diag_req(own_address, 16'h0000, 2));
		send_frame(read_req(own_address, mbrtu_pkg::FN_READ_HOLD, 16'd0, mbrtu_pkg::READ_MAX));
	endtask

	task automatic test_exception_replies();
		byte_q_t f;
		send_frame(read_req(own_address, mbrtu_pkg::FN_READ_HOLD, 16'd0, 8'd0));
		send_frame(read_req(own_address, mbrtu_pkg::FN_READ_INPUT, 16'd0, 8'd126));
		send_frame(write_req(own_address, 16'd0, 8'd1, 8'd3));
		// A register count above the write limit is refused before the data is looked at.
		f = {own_address, mbrtu_pkg::FN_WRITE_MULT, 8'h00, 8'h00, 8'h00, 8'd124, 8'd248};
		send_frame(with_crc(f));
		send_frame(read_req(own_address, mbrtu_pkg::FN_READ_HOLD, 16'd255, 8'd2));
		send_frame(read_req(own_address, mbrtu_pkg::FN_READ_HOLD, 16'hFFFF, 8'd1));
		send_frame(read_req(own_address, FN_CUSTOM_A, 16'd0, 8'd1));
		send_frame(read_req(own_address, FN_CUSTOM_B, 16'd0, 8'd1));
		send_frame(read_req(own_address, 8'hFF, 16'd0, 8'd1));
		send_frame(diag_req(own_address, 16'h0001, 2));
		// Request fields that lie past the received data read as zero.
		f = {own_address, mbrtu_pkg::FN_READ_HOLD};
		send_frame(with_crc(f));
	endtask

	task automatic test_dropped_frames();
		byte_q_t f;
		f = read_req(own_address, mbrtu_pkg::FN_READ_HOLD, 16'd0, 8'd1);
		f[f.size()-1] ^= 8'h01;
		send_frame(f);
		send_frame(read_req(own_address + 8'd1, mbrtu_pkg::FN_READ_HOLD, 16'd0, 8'd1));
		send_frame({own_address, mbrtu_pkg::FN_READ_HOLD, 8'h00});
		// A receive error halfway through throws the partial frame away.
		send_item(mbrtu_pkg::OP_BYTE, own_address, 8'h00, 16'h0000);
		send_item(mbrtu_pkg::OP_BYTE, 8'hFF, 8'hFF, 16'hFFFF);
		send_item(mbrtu_pkg::OP_RXERR, 8'h00, 8'h00, 16'h0000);
		send_frame(read_req(own_address, mbrtu_pkg::FN_READ_HOLD, 16'd0, 8'd3));
		send_frame(write_req(BROADCAST, 16'd5, 8'd3, 8'd6));
		send_frame(read_req(own_address, mbrtu_pkg::FN_READ_HOLD, 16'd5, 8'd3));
		// Echo of 251 data bytes makes an answer too long to send.
		send_frame(diag_req(own_address, 16'h0000, 251));
		f = diag_req(own_address, 16'h0000, 252);
		send_frame(f);
	endtask

	task automatic test_local_access();
		send_item(mbrtu_pkg::OP_LWRITE, 8'h00, 8'hFF, 16'hFFFF);
		send_item(mbrtu_pkg::OP_LWRITE, 8'h00, 8'h00, 16'h0000);
		send_item(mbrtu_pkg::OP_LREAD, 8'h00, 8'hFF, 16'h0000);
		send_item(mbrtu_pkg::OP_LREAD, 8'h00, 8'h00, 16'hFFFF);
		send_item(OP_SPARE_LO, 8'hFF, 8'h01, 16'h1234);
		send_item(OP_SPARE_HI, 8'h00, 8'h02, 16'h4321);
		send_item(mbrtu_pkg::OP_LREAD, 8'h00, 8'h01, 16'h0000);
	endtask

	function automatic logic [15:0] pick_start();
		if ($urandom_range(9) == 0) begin
			return 16'($urandom);
		end
		return 16'($urandom_range(top_register));
	endfunction

	task automatic test_random_traffic(int n_items);
		int stop_at;
		int r;
		logic [7:0] a;
		byte_q_t f;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			r = $urandom_range(99);
			a = ($urandom_range(9) == 0) ? BROADCAST : own_address;
			if (r < 25) begin
				send_frame(read_req(a, $urandom_range(1) ? mbrtu_pkg::FN_READ_HOLD :
					mbrtu_pkg::FN_READ_INPUT, pick_start(), 8'($urandom_range(1, 6))));
			end else if (r < 45) begin
				r = $urandom_range(1, 5);
				send_frame(write_req(a, pick_start(), 8'(r),
					($urandom_range(7) == 0) ? 8'(2 * r + 1) : 8'(2 * r)));
			end else if (r < 52) begin
				send_frame(diag_req(a, ($urandom_range(4) == 0) ? 16'($urandom) : 16'h0,
					$urandom_range(0, 6)));
			end else if (r < 56) begin
				send_frame(read_req(a, 8'($urandom), 16'($urandom), 8'($urandom)));
			end else if (r < 62) begin
				f = read_req($urandom_range(1) ? own_address : 8'($urandom),
					mbrtu_pkg::FN_READ_HOLD, pick_start(), 8'd1);
				if ($urandom_range(1)) begin
					f[$urandom_range(f.size() - 1)] ^= 8'(1 << $urandom_range(7));
				end
				send_frame(f);
			end else if (r < 66) begin
				for (int i = $urandom_range(1, 4); i > 0; i--) begin
					send_item(mbrtu_pkg::OP_BYTE, 8'($urandom), 8'($urandom), 16'($urandom));
				end
				send_item(mbrtu_pkg::OP_RXERR, 8'($urandom), 8'($urandom), 16'($urandom));
			end else if (r < 80) begin
				send_item(mbrtu_pkg::OP_LWRITE, 8'($urandom), 8'($urandom), 16'($urandom));
			end else if (r < 95) begin
				send_item(mbrtu_pkg::OP_LREAD, 8'($urandom), 8'($urandom), 16'($urandom));
			end else begin
				send_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 8'($urandom),
					8'($urandom), 16'($urandom));
			end
		end
	endtask

	task automatic check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			err_count++;
		end
	endtask

	// Every word popped is compared against the oldest expected one.
	always @(posedge clk) begin
		reply_word_t w;
		if (arst_n && pop && !empty) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected word popped: kind %0d count %0d", kind, tx_count);
				err_count++;
			end else begin
				w = pending_replies.pop_front();
				check_field("kind", w.kind, kind);
				check_field("tx_byte0", w.tx_b[0], tx_byte0);
				check_field("tx_byte1", w.tx_b[1], tx_byte1);
				check_field("tx_byte2", w.tx_b[2], tx_byte2);
				check_field("tx_byte3", w.tx_b[3], tx_byte3);
				check_field("tx_count", w.cnt, tx_count);
				check_field("tx_last", w.last, tx_last);
				check_field("local_value", w.value, local_value);
				words_checked++;
			end
		end
	end

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		op <= mbrtu_pkg::OP_BYTE;
		rx_byte <= '0;
		reg_index <= '0;
		reg_value <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_SLAVE;
		pwdata <= '0;
		own_address = 8'd1;
		top_register = 8'd255;
		rx_len = 0;
		rx_overflow = 1'b0;
		foreach (holding_regs[i]) begin
			holding_regs[i] = '0;
		end
		err_count = 0;
		words_checked = 0;
		items_sent = 0;
		frames_sent = 0;
		idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_basic_functions();
		test_exception_replies();
		test_dropped_frames();
		test_local_access();

		configure(8'd255, 8'd0);
		send_frame(read_req(own_address, mbrtu_pkg::FN_READ_HOLD, 16'd0, 8'd1));
		send_frame(read_req(own_address, mbrtu_pkg::FN_READ_HOLD, 16'd0, 8'd2));
		test_random_traffic(50);

		configure(8'd1, 8'd255);
		idle_pct = 72;
		test_random_traffic(50);

		configure(8'($urandom_range(1, 255)), 8'($urandom));
		idle_pct = 0;
		stall_pct = 72;
		test_random_traffic(50);

		configure(8'($urandom_range(1, 255)), 8'($urandom_range(16, 255)));
		idle_pct = 10;
		stall_pct = 10;
		test_random_traffic(50);

		drain();
		$display("Covered %0d items in %0d frames plus local accesses, %0d words checked,",
			items_sent, frames_sent, words_checked);
		$display("over four address and register-limit settings and four idling phases.");
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire
